FILE: src/vn4_pkg.sv
// Package for the 4D value noise block: widths, opcodes, state codes and the
// structs passed between the walker, the blender and the top level.
// No dependencies.
package vn4_pkg;

   localparam int TABLE_SIZE = 256;
   localparam int FRAC_BITS  = 16;
   localparam int VALUE_BITS = 16;

   localparam int IDX_BITS   = $clog2(TABLE_SIZE);
   localparam int PERM_BITS  = 8;
   localparam int COORD_BITS = 32;
   localparam int NUM_LVL    = 4;
   localparam int LVL_BITS   = $clog2(NUM_LVL);
   localparam int BLV_BITS   = $clog2(NUM_LVL + 1);
   localparam int CNT_BITS   = NUM_LVL;
   localparam int DIFF_BITS  = VALUE_BITS + 1;
   localparam int PROD_BITS  = VALUE_BITS + FRAC_BITS + 2;

   localparam int REQ_DATA_BITS = 160;
   localparam int REQ_USER_BITS = 1;
   localparam int RSP_DATA_BITS = 16;

   localparam logic [LVL_BITS-1:0] LVL_LAST  = LVL_BITS'(NUM_LVL - 1);
   localparam logic [BLV_BITS-1:0] LVL_FINAL = BLV_BITS'(NUM_LVL);

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef logic [IDX_BITS-1:0]          idx_type;
   typedef logic signed [VALUE_BITS-1:0] val_type;
   typedef logic [FRAC_BITS-1:0]         frac_type;
   typedef logic [PERM_BITS-1:0]         perm_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_SEND
   } state_type;

   // base: hash levels, 0 = t, 1 = z, 2 = y, 3 = x
   // frac: blend levels, 0 = x, 1 = y, 2 = z, 3 = t
   typedef struct packed {
      logic [NUM_LVL-1:0][IDX_BITS-1:0]  base;
      logic [NUM_LVL-1:0][FRAC_BITS-1:0] frac;
   } query_type;

   typedef struct packed {
      logic     load;
      logic     start;
      idx_type  index;
      val_type  value;
      perm_type perm;
   } walk_ctl_type;

   typedef struct packed {
      logic                valid;
      logic [CNT_BITS-1:0] idx;
      val_type             value;
   } corner_type;

   typedef struct packed {
      logic    valid;
      val_type value;
   } result_type;

endpackage

FILE: src/vn4_ram.sv
// Generic single-port synchronous RAM, registered read, write has priority.
// No dependencies.
module vn4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end else begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/vn4_walk.sv
// Corner walker: owns the permutation and value tables, walks the 16 lattice
// corners depth first and streams out corner values. Uses vn4_pkg, vn4_ram.
module vn4_walk (
   input  logic                  clock,
   input  logic                  reset,
   input  vn4_pkg::walk_ctl_type ctl,
   input  vn4_pkg::query_type    query,
   output vn4_pkg::corner_type   corner
);
   import vn4_pkg::*;

   logic                busy_ff, busy_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [LVL_BITS-1:0] lvl_ff, lvl_in;
   logic                prd_ff, prd_in;
   logic [LVL_BITS-1:0] prd_lvl_ff, prd_lvl_in;
   logic [CNT_BITS-1:0] pc_ff, pc_in;
   logic                vrd_ff, vrd_in;
   logic [CNT_BITS-1:0] vc_ff, vc_in;
   perm_type            stack_ff [NUM_LVL-1];

   perm_type            perm_rdata;
   val_type             value_rdata;
   idx_type             perm_addr;
   idx_type             value_addr;
   idx_type             parent;
   logic                axis_bit;
   logic                fwd;
   logic [CNT_BITS-1:0] cnt_next;
   logic [LVL_BITS-1:0] lvl_prev;

   // first level to re-read when the corner count steps to n
   function automatic logic [LVL_BITS-1:0] first_lvl(input logic [CNT_BITS-1:0] n);
      logic [LVL_BITS-1:0] l;
      if (n[0]) l = LVL_BITS'(3);
      else if (n[1]) l = LVL_BITS'(2);
      else if (n[2]) l = LVL_BITS'(1);
      else l = LVL_BITS'(0);
      return l;
   endfunction

   vn4_ram #(.WIDTH(PERM_BITS), .DEPTH(TABLE_SIZE)) u_perm (
      .clock (clock),
      .we    (ctl.load),
      .addr  (perm_addr),
      .wdata (ctl.perm),
      .rdata (perm_rdata)
   );

   vn4_ram #(.WIDTH(VALUE_BITS), .DEPTH(TABLE_SIZE)) u_value (
      .clock (clock),
      .we    (ctl.load),
      .addr  (value_addr),
      .wdata (ctl.value),
      .rdata (value_rdata)
   );

   always_comb begin
      lvl_prev = lvl_ff - 1'b1;
      axis_bit = cnt_ff[LVL_LAST - lvl_ff];
      fwd = prd_ff && (lvl_ff != '0) && (prd_lvl_ff == lvl_prev);
      if (lvl_ff == '0) begin
         parent = '0;
      end else if (fwd) begin
         parent = IDX_BITS'(perm_rdata);
      end else begin
         parent = IDX_BITS'(stack_ff[lvl_prev]);
      end
      if (ctl.load) begin
         perm_addr  = ctl.index;
         value_addr = ctl.index;
      end else begin
         perm_addr  = query.base[lvl_ff] + IDX_BITS'(axis_bit) + parent;
         value_addr = IDX_BITS'(perm_rdata);
      end

      cnt_next = cnt_ff + 1'b1;
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      lvl_in   = lvl_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         lvl_in  = '0;
      end else if (busy_ff) begin
         if (lvl_ff == LVL_LAST) begin
            if (cnt_ff == '1) begin
               busy_in = 1'b0;
            end else begin
               cnt_in = cnt_next;
               lvl_in = first_lvl(cnt_next);
            end
         end else begin
            lvl_in = lvl_ff + 1'b1;
         end
      end

      prd_in     = busy_ff;
      prd_lvl_in = lvl_ff;
      pc_in      = cnt_ff;
      vrd_in     = prd_ff && (prd_lvl_ff == LVL_LAST);
      vc_in      = pc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         prd_ff  <= 1'b0;
         vrd_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         prd_ff  <= prd_in;
         vrd_ff  <= vrd_in;
      end
      cnt_ff     <= cnt_in;
      lvl_ff     <= lvl_in;
      prd_lvl_ff <= prd_lvl_in;
      pc_ff      <= pc_in;
      vc_ff      <= vc_in;
      if (prd_ff && (prd_lvl_ff != LVL_LAST)) begin
         stack_ff[prd_lvl_ff] <= perm_rdata;
      end
   end

   assign corner.valid = vrd_ff;
   assign corner.idx   = vc_ff;
   assign corner.value = value_rdata;

endmodule

FILE: src/vn4_blend.sv
// Quadrilinear blender: folds the corner stream pairwise through one shared
// two-stage lerp unit. Uses vn4_pkg.
module vn4_blend (
   input  logic                clock,
   input  logic                reset,
   input  vn4_pkg::corner_type corner,
   input  vn4_pkg::query_type  query,
   output vn4_pkg::result_type result
);
   import vn4_pkg::*;

   val_type                     pend_ff [NUM_LVL];
   val_type                     pend_in [NUM_LVL];

   logic                        s1_valid_ff, s1_valid_in;
   logic [BLV_BITS-1:0]         s1_lvl_ff, s1_lvl_in;
   logic [CNT_BITS-1:0]         s1_idx_ff, s1_idx_in;
   val_type                     s1_a_ff, s1_a_in;
   logic signed [PROD_BITS-1:0] s1_prod_ff, s1_prod_in;

   logic                        r_valid_ff, r_valid_in;
   logic [BLV_BITS-1:0]         r_lvl_ff, r_lvl_in;
   logic [CNT_BITS-1:0]         r_idx_ff, r_idx_in;
   val_type                     r_val_ff, r_val_in;

   logic                        r_live, r_launch, v_launch;
   logic [BLV_BITS-1:0]         op_lvl;
   logic [CNT_BITS-1:0]         op_idx;
   val_type                     op_a, op_b;
   frac_type                    op_w;
   logic signed [DIFF_BITS-1:0] diff;

   always_comb begin
      r_live   = r_valid_ff && (r_lvl_ff != LVL_FINAL);
      r_launch = r_live && r_idx_ff[0];
      v_launch = corner.valid && corner.idx[0];

      pend_in = pend_ff;
      if (corner.valid && !corner.idx[0]) begin
         pend_in[0] = corner.value;
      end
      if (r_live && !r_idx_ff[0]) begin
         pend_in[r_lvl_ff[LVL_BITS-1:0]] = r_val_ff;
      end

      if (r_launch) begin
         op_lvl = r_lvl_ff;
         op_idx = r_idx_ff;
         op_a   = pend_ff[r_lvl_ff[LVL_BITS-1:0]];
         op_b   = r_val_ff;
      end else begin
         op_lvl = '0;
         op_idx = corner.idx;
         op_a   = pend_ff[0];
         op_b   = corner.value;
      end
      op_w = query.frac[op_lvl[LVL_BITS-1:0]];
      diff = DIFF_BITS'(op_b) - DIFF_BITS'(op_a);

      s1_valid_in = r_launch || v_launch;
      s1_lvl_in   = op_lvl + 1'b1;
      s1_idx_in   = op_idx >> 1;
      s1_a_in     = op_a;
      s1_prod_in  = PROD_BITS'(diff) * PROD_BITS'($signed({1'b0, op_w}));

      r_valid_in = s1_valid_ff;
      r_lvl_in   = s1_lvl_ff;
      r_idx_in   = s1_idx_ff;
      r_val_in   = s1_a_ff + s1_prod_ff[FRAC_BITS +: VALUE_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         r_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         r_valid_ff  <= r_valid_in;
      end
      pend_ff    <= pend_in;
      s1_lvl_ff  <= s1_lvl_in;
      s1_idx_ff  <= s1_idx_in;
      s1_a_ff    <= s1_a_in;
      s1_prod_ff <= s1_prod_in;
      r_lvl_ff   <= r_lvl_in;
      r_idx_ff   <= r_idx_in;
      r_val_ff   <= r_val_in;
   end

   assign result.valid = r_valid_ff && (r_lvl_ff == LVL_FINAL);
   assign result.value = r_val_ff;

endmodule

FILE: src/value_noise_4d.sv
// 4D lattice value noise with quadrilinear interpolation, streaming ports.
// Top level; uses vn4_pkg, vn4_walk, vn4_blend.
//
// A load transaction (tuser = 0) writes one entry of the value table and of
// the permutation table in its accept cycle and gives no result; loads are
// taken back to back. A query transaction (tuser = 1) returns one Q1.15 value,
// and the next transaction is accepted once that value has moved into the
// output register. The time from the acceptance of a query to its result is
// set by the single-port permutation table: the 30 chained hash reads of the
// 16 corners issue one per cycle, the 16 value reads overlap them on the
// value table, and the two-stage lerp unit adds the tail. Both tables are
// undefined after reset and must be loaded before they are queried; there is
// no clearing pass.
module value_noise_4d (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // entry_index, noise_entry, perm_entry, coord_x, coord_y, coord_z, coord_t
   input  logic [vn4_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // opcode
   input  logic [vn4_pkg::REQ_USER_BITS-1:0] req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // noise_out
   output logic [vn4_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import vn4_pkg::*;

   state_type                 state_ff, state_in;
   query_type                 query_ff, query_in;
   val_type                   res_ff, res_in;
   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata_ff, rsp_tdata_in;

   walk_ctl_type              ctl;
   corner_type                corner;
   result_type                result;

   logic                      accept;
   logic                      out_free;
   logic [7:0]                entry_index;
   logic signed [15:0]        noise_entry;
   logic [7:0]                perm_entry;
   logic signed [COORD_BITS-1:0] coord [NUM_LVL];
   logic signed [COORD_BITS-1:0] whole [NUM_LVL];

   vn4_walk u_walk (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .query  (query_ff),
      .corner (corner)
   );

   vn4_blend u_blend (
      .clock  (clock),
      .reset  (reset),
      .corner (corner),
      .query  (query_ff),
      .result (result)
   );

   always_comb begin
      req_tready  = (state_ff == ST_IDLE);
      accept      = req_tvalid && req_tready;
      out_free    = !rsp_tvalid_ff || rsp_tready;

      entry_index = req_tdata[7:0];
      noise_entry = req_tdata[23:8];
      perm_entry  = req_tdata[31:24];
      // coord order: x, y, z, t
      for (int i = 0; i < NUM_LVL; i++) begin
         coord[i] = req_tdata[32 + i*COORD_BITS +: COORD_BITS];
         whole[i] = coord[i] >>> FRAC_BITS;
      end

      ctl.load  = accept && (req_tuser[0] == OP_LOAD);
      ctl.start = accept && (req_tuser[0] == OP_QUERY);
      ctl.index = IDX_BITS'(entry_index);
      ctl.value = VALUE_BITS'(noise_entry);
      ctl.perm  = PERM_BITS'(perm_entry);

      query_in = query_ff;
      if (ctl.start) begin
         for (int i = 0; i < NUM_LVL; i++) begin
            query_in.base[NUM_LVL-1-i] = whole[i][IDX_BITS-1:0];
            query_in.frac[i]           = coord[i][FRAC_BITS-1:0];
         end
      end

      state_in      = state_ff;
      res_in        = res_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (result.valid) begin
               res_in   = result.value;
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = RSP_DATA_BITS'(res_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      query_ff     <= query_in;
      res_ff       <= res_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
